>>> rtl/stq_pkg.sv
`default_nettype none

package stq_pkg;

    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADJUST = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd5;

    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic insert;
        logic remove;
    } stq_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/stq_cell.sv
`default_nettype none

module stq_cell
    import stq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5,
    parameter int POS_W = 4
)
(
    input  wire logic              clk,
    input  wire stq_ctrl_t         ctrl,
    input  wire logic [CNT_W-1:0]  count,
    input  wire logic [POS_W-1:0]  pos,
    input  wire logic [TIME_W-1:0] new_exp,
    input  wire logic [ID_W-1:0]   new_id,
    input  wire logic              left_gt,
    input  wire logic [TIME_W-1:0] left_exp,
    input  wire logic [ID_W-1:0]   left_id,
    input  wire logic [TIME_W-1:0] right_exp,
    input  wire logic [ID_W-1:0]   right_id,
    output logic      [TIME_W-1:0] exp,
    output logic      [ID_W-1:0]   id,
    output logic                   gt,
    output logic                   match
);

    logic [TIME_W-1:0] exp_reg;
    logic [TIME_W-1:0] exp_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic              valid;

    assign valid = CNT_W'(INDEX) < count;
    assign gt    = !valid || (exp_reg > new_exp);
    assign match = valid && (id_reg == new_id);
    assign exp   = exp_reg;
    assign id    = id_reg;

    always_comb
    begin
        exp_next = exp_reg;
        id_next  = id_reg;
        if (ctrl.insert)
        begin
            if (left_gt)
            begin
                exp_next = left_exp;
                id_next  = left_id;
            end
            else if (gt)
            begin
                exp_next = new_exp;
                id_next  = new_id;
            end
        end
        else if (ctrl.remove && (POS_W'(INDEX) >= pos))
        begin
            exp_next = right_exp;
            id_next  = right_id;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        id_reg  <= id_next;
    end

endmodule

`default_nettype wire

>>> rtl/sorted_timer_queue.sv
// Channel   Handshake                 Payload
// command   start in, busy out        operation, timer_id, expire_time, now
// result    result_valid out          expired_id, status, last
//
// Add steps through find and insert, delete through find and remove, adjust through all three.
// Tick latches its command, then gives one result per cycle, up to MAX_RESULTS.
// The sequencer walks find, remove, insert and tick; all shifting cells move in the same cycle.
// Reset empties the queue at once; the cell storage is not cleared.
// The receiver cannot stall; each result is on the ports for exactly one cycle.
`default_nettype none

module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int MAX_TIMERS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [ID_W-1:0]     timer_id,
    input  wire logic [TIME_W-1:0]   expire_time,
    input  wire logic [TIME_W-1:0]   now,
    output logic                     result_valid,
    output logic      [ID_W-1:0]     expired_id,
    output logic      [STATUS_W-1:0] status,
    output logic                     last
);

    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam int POS_W = $clog2(MAX_TIMERS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_REMOVE = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_TICK   = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [TIME_W-1:0]    exp_reg, exp_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic                 valid_reg, valid_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 last_reg, last_next;

    stq_ctrl_t         ctrl;
    logic [POS_W-1:0]  cell_pos;
    logic [TIME_W-1:0] cell_exp [MAX_TIMERS];
    logic [ID_W-1:0]   cell_id  [MAX_TIMERS];
    logic              cell_gt  [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] cell_match;
    logic              found;
    logic [POS_W-1:0]  match_pos;
    logic              head_due;
    logic              next_due;

    assign busy         = state_reg != S_IDLE;
    assign result_valid = valid_reg;
    assign expired_id   = out_id_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    assign cell_pos = (state_reg == S_TICK) ? '0 : pos_reg;

    for (genvar i = 0; i < MAX_TIMERS; i++)
    begin : g_cell
        logic              l_gt;
        logic [TIME_W-1:0] l_exp;
        logic [ID_W-1:0]   l_id;
        logic [TIME_W-1:0] r_exp;
        logic [ID_W-1:0]   r_id;

        if (i == 0)
        begin : g_first
            assign l_gt  = 1'b0;
            assign l_exp = exp_reg;
            assign l_id  = id_reg;
        end
        else
        begin : g_inner
            assign l_gt  = cell_gt[i-1];
            assign l_exp = cell_exp[i-1];
            assign l_id  = cell_id[i-1];
        end

        if (i == MAX_TIMERS - 1)
        begin : g_end
            assign r_exp = cell_exp[i];
            assign r_id  = cell_id[i];
        end
        else
        begin : g_mid
            assign r_exp = cell_exp[i+1];
            assign r_id  = cell_id[i+1];
        end

        stq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W),
            .POS_W (POS_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .pos       (cell_pos),
            .new_exp   (exp_reg),
            .new_id    (id_reg),
            .left_gt   (l_gt),
            .left_exp  (l_exp),
            .left_id   (l_id),
            .right_exp (r_exp),
            .right_id  (r_id),
            .exp       (cell_exp[i]),
            .id        (cell_id[i]),
            .gt        (cell_gt[i]),
            .match     (cell_match[i])
        );
    end

    assign found = |cell_match;

    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < MAX_TIMERS; i++)
        begin
            if (cell_match[i])
            begin
                match_pos = match_pos | POS_W'(i);
            end
        end
    end

    assign head_due = (count_reg != '0) && (cell_exp[0] <= now_reg);
    assign next_due = (count_reg > CNT_W'(1)) && (cell_exp[1] <= now_reg)
                      && (n_reg + RES_CNT_W'(1) < RES_CNT_W'(MAX_RESULTS));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        pos_next    = pos_reg;
        op_next     = op_reg;
        id_next     = id_reg;
        exp_next    = exp_reg;
        now_next    = now_reg;
        valid_next  = 1'b0;
        out_id_next = out_id_reg;
        status_next = status_reg;
        last_next   = last_reg;
        ctrl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = operation;
                    id_next  = timer_id;
                    exp_next = expire_time;
                    now_next = now;
                    n_next   = '0;
                    state_next = (operation == OP_TICK) ? S_TICK : S_FIND;
                end
            end
            S_FIND:
            begin
                pos_next    = match_pos;
                out_id_next = id_reg;
                last_next   = 1'b1;
                if (op_reg == OP_ADD)
                begin
                    if (found)
                    begin
                        valid_next  = 1'b1;
                        status_next = ST_DUPLICATE;
                        state_next  = S_IDLE;
                    end
                    else if (count_reg == CNT_W'(MAX_TIMERS))
                    begin
                        valid_next  = 1'b1;
                        status_next = ST_FULL;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_INSERT;
                    end
                end
                else if (!found)
                begin
                    valid_next  = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                ctrl.remove = 1'b1;
                count_next  = count_reg - CNT_W'(1);
                if (op_reg == OP_ADJUST)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    valid_next  = 1'b1;
                    status_next = ST_DONE;
                    state_next  = S_IDLE;
                end
            end
            S_INSERT:
            begin
                ctrl.insert = 1'b1;
                count_next  = count_reg + CNT_W'(1);
                valid_next  = 1'b1;
                status_next = ST_DONE;
                state_next  = S_IDLE;
            end
            S_TICK:
            begin
                valid_next = 1'b1;
                if (head_due)
                begin
                    ctrl.remove = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                    n_next      = n_reg + RES_CNT_W'(1);
                    out_id_next = cell_id[0];
                    status_next = ST_EXPIRED;
                    last_next   = !next_due;
                    if (!next_due)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    out_id_next = '0;
                    status_next = ST_NONE_DUE;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        pos_reg    <= pos_next;
        op_reg     <= op_next;
        id_reg     <= id_next;
        exp_reg    <= exp_next;
        now_reg    <= now_next;
        out_id_reg <= out_id_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire
